// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, reset named reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BTP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked in and out of reset
`define BTP_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/btp_pkg.sv
// ---------------------------------------------------------------------------
// btp_pkg
// Widths, status codes and sideband types of the belt tangent pipeline.
// ---------------------------------------------------------------------------
package btp_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QF_BITS       = 24;

   localparam int COORD_W  = 32;
   localparam int DIA_W    = 31;
   localparam int ADIFF_W  = COORD_W + 1;            // |2 * centre difference|
   localparam int K_W      = DIA_W + 1;
   localparam int SQ_W     = 2 * ADIFF_W;
   localparam int KK_W     = 2 * K_W;
   localparam int S_W      = SQ_W + 2;
   localparam int PK_W     = K_W + ADIFF_W;
   localparam int RAD_W    = S_W + 2 * QF_BITS;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int QH_W     = ROOT_W / 2;
   localparam int QP_W     = ADIFF_W + QH_W;
   localparam int BT_W     = ADIFF_W + ROOT_W;
   localparam int AT_W     = PK_W + QF_BITS;
   localparam int SUM_W    = BT_W + 3;
   localparam int CHUNK_W  = DIA_W;
   localparam int MAG_W    = SUM_W - 1;
   localparam int MP_W     = CHUNK_W + DIA_W;
   localparam int DEN_W    = S_W + QF_BITS + 1;
   localparam int QUO_W    = 32;
   localparam int NUMER_W  = DEN_W + QUO_W;
   localparam int LANES    = 4;
   localparam int VW       = COORD_W + 2;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DEGEN  = 2'd1,
      STATUS_NO_TAN = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic [DIA_W-1:0]          d1;
      logic [DIA_W-1:0]          d2;
      logic                      s1neg;
      logic                      s2neg;
      logic [ADIFF_W-1:0]        adx;
      logic [ADIFF_W-1:0]        ady;
      logic                      ndx;
      logic                      ndy;
      logic                      kneg;
      logic                      eneg;
      logic [S_W-1:0]            s;
      logic [PK_W-1:0]           pkx;
      logic [PK_W-1:0]           pky;
      status_type                status;
   } front_side_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      status_type                status;
      logic [LANES-1:0]          neg;
   } tail_side_type;

endpackage

// File: rtl/belt_tangent_points.sv
// Pipeline: an accepted request word passes the front stages, the square root,
// the numerator stages, the divider and the output register to its response word.
// Throughput: one word per cycle; the square root and the divider are fully
// pipelined, one bit per stage. A stalled response freezes the whole pipe.
// Reset: synchronous, active high; clears all valid bits, the pipe comes up
// empty and ready on the next cycle.
// ---------------------------------------------------------------------------
// belt_tangent_points
// Tangent points of the belt span between two pulleys, signed fixed point.
// ---------------------------------------------------------------------------
module belt_tangent_points import btp_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_first_x,
   input  logic signed [COORD_W-1:0] req_first_y,
   input  logic [DIA_W-1:0]          req_first_diameter,
   input  logic                      req_first_reverse,
   input  logic signed [COORD_W-1:0] req_second_x,
   input  logic signed [COORD_W-1:0] req_second_y,
   input  logic [DIA_W-1:0]          req_second_diameter,
   input  logic                      req_second_reverse,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_start_x,
   output logic signed [COORD_W-1:0] rsp_start_y,
   output logic signed [COORD_W-1:0] rsp_end_x,
   output logic signed [COORD_W-1:0] rsp_end_y,
   output logic [1:0]                rsp_status
);

   localparam int SAT_BITS = (WORD_BITS < COORD_W) ? WORD_BITS : COORD_W;
   localparam logic signed [VW-1:0] SAT_HI = (VW'(1) <<< (SAT_BITS - 1)) - VW'(1);
   localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);
   localparam int FSIDE_W = $bits(front_side_type);
   localparam int TSIDE_W = $bits(tail_side_type);

   logic en;

   logic                 fr_valid;
   logic [RAD_W-1:0]     fr_rad;
   front_side_type       fr_side;

   logic                 sq_valid;
   logic [ROOT_W-1:0]    sq_root;
   logic [FSIDE_W-1:0]   sq_side_vec;
   front_side_type       sq_side;

   logic                          nm_valid;
   logic [LANES-1:0][NUMER_W-1:0] nm_numer;
   logic [DEN_W-1:0]              nm_den;
   tail_side_type                 nm_side;

   logic                        dv_valid;
   logic [LANES-1:0][QUO_W-1:0] dv_quo;
   logic [TSIDE_W-1:0]          dv_side_vec;
   tail_side_type               dv_side;

   logic signed [COORD_W-1:0] ctr    [LANES];
   logic signed [VW-1:0]      off    [LANES];
   logic signed [VW-1:0]      pos    [LANES];
   logic signed [COORD_W-1:0] pt_in  [LANES];

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] pt_ff  [LANES];
   status_type                rsp_status_ff;

   // the pipe moves whenever the output register is free or being emptied
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   btp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .en                 (en),
      .in_valid           (req_valid),
      .in_first_x         (req_first_x),
      .in_first_y         (req_first_y),
      .in_first_diameter  (req_first_diameter),
      .in_first_reverse   (req_first_reverse),
      .in_second_x        (req_second_x),
      .in_second_y        (req_second_y),
      .in_second_diameter (req_second_diameter),
      .in_second_reverse  (req_second_reverse),
      .out_valid          (fr_valid),
      .out_rad            (fr_rad),
      .out_side           (fr_side)
   );

   btp_sqrt #(.RAD_W(RAD_W), .ROOT_W(ROOT_W), .SIDE_W(FSIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_vec)
   );

   assign sq_side = sq_side_vec;

   btp_num u_num (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (nm_valid),
      .out_numer (nm_numer),
      .out_den   (nm_den),
      .out_side  (nm_side)
   );

   btp_div #(
      .LANES   (LANES),
      .NUMER_W (NUMER_W),
      .DEN_W   (DEN_W),
      .QUO_W   (QUO_W),
      .SIDE_W  (TSIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_valid),
      .in_numer  (nm_numer),
      .in_den    (nm_den),
      .in_side   (nm_side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side_vec)
   );

   assign dv_side = dv_side_vec;
   assign ctr[0]  = dv_side.x1;
   assign ctr[1]  = dv_side.y1;
   assign ctr[2]  = dv_side.x2;
   assign ctr[3]  = dv_side.y2;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         off[l] = dv_side.neg[l] ? -$signed({2'b00, dv_quo[l]}) : $signed({2'b00, dv_quo[l]});
         pos[l] = {{2{ctr[l][COORD_W-1]}}, ctr[l]} + off[l];
         if (dv_side.status != STATUS_OK) begin
            pt_in[l] = '0;
         end else if (pos[l] > SAT_HI) begin
            pt_in[l] = COORD_W'(SAT_HI);
         end else if (pos[l] < SAT_LO) begin
            pt_in[l] = COORD_W'(SAT_LO);
         end else begin
            pt_in[l] = COORD_W'(pos[l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff         <= pt_in;
         rsp_status_ff <= dv_side.status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_start_x = pt_ff[0];
   assign rsp_start_y = pt_ff[1];
   assign rsp_end_x   = pt_ff[2];
   assign rsp_end_y   = pt_ff[3];
   assign rsp_status  = rsp_status_ff;

endmodule

// File: rtl/btp_front.sv
// ---------------------------------------------------------------------------
// btp_front
// Centre differences, belt constant k, squares and the root argument.
// ---------------------------------------------------------------------------
module btp_front import btp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] in_first_x,
   input  logic signed [COORD_W-1:0] in_first_y,
   input  logic [DIA_W-1:0]          in_first_diameter,
   input  logic                      in_first_reverse,
   input  logic signed [COORD_W-1:0] in_second_x,
   input  logic signed [COORD_W-1:0] in_second_y,
   input  logic [DIA_W-1:0]          in_second_diameter,
   input  logic                      in_second_reverse,
   output logic                      out_valid,
   output logic [RAD_W-1:0]          out_rad,
   output front_side_type            out_side
);

   // equal-radius tolerance in raw diameter units
   localparam logic [63:0] EQ_TOL = (64'd1 << (FRAC_BITS + 1)) / 64'd1000000000;

   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W-1:0]      adx_h, ady_h;
   logic [DIA_W-1:0]        dd;
   logic [K_W-1:0]          k_in;
   front_side_type          side1_in, side2_in, side3_in, side4_in;
   logic [SQ_W-1:0]         sqx2_in, sqy2_in;
   logic [KK_W-1:0]         kk2_in;
   logic [RAD_W-1:0]        rad4_in;

   logic           v1_ff, v2_ff, v3_ff, v4_ff;
   front_side_type side1_ff, side2_ff, side3_ff, side4_ff;
   logic [K_W-1:0] k1_ff;
   logic [SQ_W-1:0] sqx2_ff, sqy2_ff;
   logic [KK_W-1:0] kk2_ff, kk3_ff;
   logic [RAD_W-1:0] rad4_ff;

   always_comb begin
      dx = {in_second_x[COORD_W-1], in_second_x} - {in_first_x[COORD_W-1], in_first_x};
      dy = {in_second_y[COORD_W-1], in_second_y} - {in_first_y[COORD_W-1], in_first_y};
      adx_h = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady_h = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      dd = (in_first_diameter >= in_second_diameter) ?
           in_first_diameter - in_second_diameter : in_second_diameter - in_first_diameter;
      side1_in       = '0;
      side1_in.x1    = in_first_x;
      side1_in.y1    = in_first_y;
      side1_in.x2    = in_second_x;
      side1_in.y2    = in_second_y;
      side1_in.d1    = in_first_diameter;
      side1_in.d2    = in_second_diameter;
      side1_in.s1neg = in_first_reverse;
      side1_in.s2neg = in_second_reverse;
      side1_in.adx   = {adx_h, 1'b0};
      side1_in.ady   = {ady_h, 1'b0};
      side1_in.ndx   = dx[COORD_W];
      side1_in.ndy   = dy[COORD_W];
      if (in_first_reverse != in_second_reverse) begin
         // crossed belt
         k_in          = K_W'(in_first_diameter) + K_W'(in_second_diameter);
         side1_in.kneg = 1'b0;
         side1_in.eneg = 1'b1;
      end else begin
         k_in          = (64'(dd) <= EQ_TOL) ? '0 : K_W'(dd);
         side1_in.kneg = in_first_diameter < in_second_diameter;
         side1_in.eneg = 1'b0;
      end
      side1_in.status = ((dx == '0 && dy == '0) || in_first_diameter == '0 ||
                         in_second_diameter == '0) ? STATUS_DEGEN : STATUS_OK;
   end

   always_comb begin
      sqx2_in      = SQ_W'(side1_ff.adx) * SQ_W'(side1_ff.adx);
      sqy2_in      = SQ_W'(side1_ff.ady) * SQ_W'(side1_ff.ady);
      kk2_in       = KK_W'(k1_ff) * KK_W'(k1_ff);
      side2_in     = side1_ff;
      side2_in.pkx = PK_W'(k1_ff) * PK_W'(side1_ff.adx);
      side2_in.pky = PK_W'(k1_ff) * PK_W'(side1_ff.ady);
   end

   always_comb begin
      side3_in   = side2_ff;
      side3_in.s = S_W'(sqx2_ff) + S_W'(sqy2_ff);
   end

   always_comb begin
      side4_in = side3_ff;
      if (side3_ff.status == STATUS_OK && side3_ff.s < S_W'(kk3_ff)) begin
         side4_in.status = STATUS_NO_TAN;
      end
      rad4_in = {side3_ff.s - S_W'(kk3_ff), {(2*QF_BITS){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         k1_ff    <= k_in;
         side2_ff <= side2_in;
         sqx2_ff  <= sqx2_in;
         sqy2_ff  <= sqy2_in;
         kk2_ff   <= kk2_in;
         side3_ff <= side3_in;
         kk3_ff   <= kk2_ff;
         side4_ff <= side4_in;
         rad4_ff  <= rad4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_rad   = rad4_ff;
   assign out_side  = side4_ff;

endmodule

// File: rtl/btp_sqrt.sv
// ---------------------------------------------------------------------------
// btp_sqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module btp_sqrt #(
   parameter int RAD_W  = 116,
   parameter int ROOT_W = 58,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [ROOT_W];
   logic [RAD_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int B = ROOT_W - 1 - j;
      logic              valid_prev;
      logic [RAD_W-1:0]  rem_prev, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [SIDE_W-1:0] side_prev;
      logic [RAD_W+1:0]  trial;

      if (j == 0) begin : g_head
         assign valid_prev = in_valid;
         assign rem_prev   = in_rad;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_body
         assign valid_prev = valid_ff[j-1];
         assign rem_prev   = rem_ff[j-1];
         assign root_prev  = root_ff[j-1];
         assign side_prev  = side_ff[j-1];
      end

      // rem holds x - root^2; (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      always_comb begin
         trial = ({{(RAD_W+2-ROOT_W){1'b0}}, root_prev} << (B + 1)) |
                 ((RAD_W+2)'(1) << (2 * B));
         if ({2'b00, rem_prev} >= trial) begin
            rem_in  = rem_prev - trial[RAD_W-1:0];
            root_in = root_prev | (ROOT_W'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// File: rtl/btp_num.sv
// ---------------------------------------------------------------------------
// btp_num
// Tangent numerators: products with the root, signed sums, magnitudes and
// scaling by the diameters, plus the rounding half and the denominator.
// ---------------------------------------------------------------------------
module btp_num import btp_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [ROOT_W-1:0]                 in_root,
   input  front_side_type                    in_side,
   output logic                              out_valid,
   output logic [LANES-1:0][NUMER_W-1:0]     out_numer,
   output logic [DEN_W-1:0]                  out_den,
   output tail_side_type                     out_side
);

   function automatic logic signed [SUM_W-1:0] sterm(input logic [MAG_W-1:0] m,
                                                      input logic neg);
      logic signed [SUM_W-1:0] t;
      t = $signed({1'b0, m});
      return neg ? -t : t;
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   front_side_type side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;

   logic [QP_W-1:0] qxl1_in, qxh1_in, qyl1_in, qyh1_in;
   logic [QP_W-1:0] qxl1_ff, qxh1_ff, qyl1_ff, qyh1_ff;
   logic [BT_W-1:0] bx2_in, by2_in, bx2_ff, by2_ff;
   logic [AT_W-1:0] ax, ay;
   logic signed [SUM_W-1:0] sum3_in [LANES];
   logic signed [SUM_W-1:0] sum3_ff [LANES];
   logic [MAG_W-1:0] mag4_in [LANES];
   logic [MAG_W-1:0] mag4_ff [LANES];
   logic [LANES-1:0] neg4_in, neg4_ff, neg5_ff;
   logic [MP_W-1:0]  mp5_in [LANES][3];
   logic [MP_W-1:0]  mp5_ff [LANES][3];
   logic [LANES-1:0][NUMER_W-1:0] numer6_in, numer6_ff;
   logic [DEN_W-1:0] den6_in, den6_ff;
   tail_side_type    tail6_in, tail6_ff;

   always_comb begin
      qxl1_in = QP_W'(in_side.adx) * QP_W'(in_root[QH_W-1:0]);
      qxh1_in = QP_W'(in_side.adx) * QP_W'(in_root[ROOT_W-1:QH_W]);
      qyl1_in = QP_W'(in_side.ady) * QP_W'(in_root[QH_W-1:0]);
      qyh1_in = QP_W'(in_side.ady) * QP_W'(in_root[ROOT_W-1:QH_W]);
   end

   always_comb begin
      bx2_in = (BT_W'(qxh1_ff) << QH_W) + BT_W'(qxl1_ff);
      by2_in = (BT_W'(qyh1_ff) << QH_W) + BT_W'(qyl1_ff);
   end

   // start uses s1, end uses s2 and the crossed-belt sign on k
   always_comb begin
      ax = AT_W'(side2_ff.pkx) << QF_BITS;
      ay = AT_W'(side2_ff.pky) << QF_BITS;
      sum3_in[0] = sterm(MAG_W'(ax), side2_ff.kneg ^ side2_ff.ndx)
                 - sterm(MAG_W'(by2_ff), side2_ff.ndy ^ side2_ff.s1neg);
      sum3_in[1] = sterm(MAG_W'(ay), side2_ff.kneg ^ side2_ff.ndy)
                 + sterm(MAG_W'(bx2_ff), side2_ff.ndx ^ side2_ff.s1neg);
      sum3_in[2] = sterm(MAG_W'(ax), side2_ff.kneg ^ side2_ff.eneg ^ side2_ff.ndx)
                 - sterm(MAG_W'(by2_ff), side2_ff.ndy ^ side2_ff.s2neg);
      sum3_in[3] = sterm(MAG_W'(ay), side2_ff.kneg ^ side2_ff.eneg ^ side2_ff.ndy)
                 + sterm(MAG_W'(bx2_ff), side2_ff.ndx ^ side2_ff.s2neg);
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         neg4_in[l] = sum3_ff[l][SUM_W-1];
         mag4_in[l] = neg4_in[l] ? MAG_W'(-sum3_ff[l]) : MAG_W'(sum3_ff[l]);
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int c = 0; c < 3; c++) begin
            mp5_in[l][c] = MP_W'(mag4_ff[l][c*CHUNK_W +: CHUNK_W]) *
                           MP_W'((l < 2) ? side4_ff.d1 : side4_ff.d2);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         numer6_in[l] = NUMER_W'(mp5_ff[l][0])
                      + (NUMER_W'(mp5_ff[l][1]) << CHUNK_W)
                      + (NUMER_W'(mp5_ff[l][2]) << (2 * CHUNK_W))
                      + (NUMER_W'(side5_ff.s) << QF_BITS);
      end
      den6_in         = DEN_W'(side5_ff.s) << (QF_BITS + 1);
      tail6_in.x1     = side5_ff.x1;
      tail6_in.y1     = side5_ff.y1;
      tail6_in.x2     = side5_ff.x2;
      tail6_in.y2     = side5_ff.y2;
      tail6_in.status = side5_ff.status;
      tail6_in.neg    = neg5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff  <= in_side;
         qxl1_ff   <= qxl1_in;
         qxh1_ff   <= qxh1_in;
         qyl1_ff   <= qyl1_in;
         qyh1_ff   <= qyh1_in;
         side2_ff  <= side1_ff;
         bx2_ff    <= bx2_in;
         by2_ff    <= by2_in;
         side3_ff  <= side2_ff;
         sum3_ff   <= sum3_in;
         side4_ff  <= side3_ff;
         mag4_ff   <= mag4_in;
         neg4_ff   <= neg4_in;
         side5_ff  <= side4_ff;
         mp5_ff    <= mp5_in;
         neg5_ff   <= neg4_ff;
         numer6_ff <= numer6_in;
         den6_ff   <= den6_in;
         tail6_ff  <= tail6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_numer = numer6_ff;
   assign out_den   = den6_ff;
   assign out_side  = tail6_ff;

endmodule

// File: rtl/btp_div.sv
// ---------------------------------------------------------------------------
// btp_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor.
// ---------------------------------------------------------------------------
module btp_div #(
   parameter int LANES   = 4,
   parameter int NUMER_W = 125,
   parameter int DEN_W   = 93,
   parameter int QUO_W   = 32,
   parameter int SIDE_W  = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUMER_W-1:0] in_numer,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][QUO_W-1:0]   out_quo,
   output logic [SIDE_W-1:0]             out_side
);

   logic                          valid_ff [QUO_W];
   logic [LANES-1:0][NUMER_W-1:0] rem_ff   [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff   [QUO_W];
   logic [DEN_W-1:0]              den_ff   [QUO_W];
   logic [SIDE_W-1:0]             side_ff  [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      localparam int B = QUO_W - 1 - j;
      logic                          valid_prev;
      logic [LANES-1:0][NUMER_W-1:0] rem_prev, rem_in;
      logic [LANES-1:0][QUO_W-1:0]   quo_prev, quo_in;
      logic [DEN_W-1:0]              den_prev;
      logic [SIDE_W-1:0]             side_prev;
      logic [NUMER_W-1:0]            dsh;

      if (j == 0) begin : g_head
         assign valid_prev = in_valid;
         assign rem_prev   = in_numer;
         assign quo_prev   = '0;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_body
         assign valid_prev = valid_ff[j-1];
         assign rem_prev   = rem_ff[j-1];
         assign quo_prev   = quo_ff[j-1];
         assign den_prev   = den_ff[j-1];
         assign side_prev  = side_ff[j-1];
      end

      always_comb begin
         dsh = NUMER_W'(den_prev) << B;
         for (int l = 0; l < LANES; l++) begin
            if (rem_prev[l] >= dsh) begin
               rem_in[l] = rem_prev[l] - dsh;
               quo_in[l] = quo_prev[l] | (QUO_W'(1) << B);
            end else begin
               rem_in[l] = rem_prev[l];
               quo_in[l] = quo_prev[l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// File: rtl/btp_checker.sv
// ---------------------------------------------------------------------------
// btp_checker
// Port-level checks of the belt tangent block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module btp_checker import btp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [COORD_W-1:0] rsp_start_x,
   input logic signed [COORD_W-1:0] rsp_start_y,
   input logic signed [COORD_W-1:0] rsp_end_x,
   input logic signed [COORD_W-1:0] rsp_end_y,
   input logic [1:0]                rsp_status
);

   // a held response word stays valid and keeps its start x, end y and status
   `BTP_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_start_x) && $stable(rsp_end_y) && $stable(rsp_status), "stalled response word changed")

   // a failed word carries no points
   `BTP_ASSERT(a_fail_zero, rsp_valid && rsp_status != STATUS_OK |-> rsp_start_x == 0 && rsp_start_y == 0 && rsp_end_x == 0 && rsp_end_y == 0, "failed word with non-zero points")

   // a blocked output freezes the pipe, so no request word may enter
   `BTP_ASSERT(a_freeze, rsp_valid && rsp_stall |-> req_stall, "request taken while output blocked")

   `BTP_ASSERT_NR(a_reset_empty, $past(reset) |-> !rsp_valid, "response word right after reset")

endmodule

bind belt_tangent_points btp_checker u_btp_checker (.*);

// File: tb/tb_belt_tangent_points.sv
// ---------------------------------------------------------------------------
// tb_belt_tangent_points
// Self-checking bench: a queue-fed driver offers pulley pairs with random
// gaps, a monitor stalls at random and checks every response word against a
// wide-integer model of the tangent points, taken in order.
// ---------------------------------------------------------------------------
module tb_belt_tangent_points;
   timeunit 1ns;
   timeprecision 1ps;
   import btp_pkg::*;

   localparam int N_RANDOM  = 1880;
   localparam int LIMIT     = 600000;
   localparam int DRAIN     = 150;
   localparam int HOLD_AT   = 500;
   localparam int HOLD_LEN  = 400;

   typedef struct {
      logic signed [COORD_W-1:0] x1, y1, x2, y2;
      logic [DIA_W-1:0]          d1, d2;
      logic                      r1, r2;
      logic                      pause;
   } pulley_pair_type;

   typedef struct {
      logic signed [COORD_W-1:0] sx, sy, ex, ey;
      status_type                status;
   } span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_first_x = '0;
   logic signed [COORD_W-1:0] req_first_y = '0;
   logic [DIA_W-1:0]          req_first_diameter = '0;
   logic                      req_first_reverse = 1'b0;
   logic signed [COORD_W-1:0] req_second_x = '0;
   logic signed [COORD_W-1:0] req_second_y = '0;
   logic [DIA_W-1:0]          req_second_diameter = '0;
   logic                      req_second_reverse = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic [1:0]                rsp_status;

   pulley_pair_type pending[$];
   span_type        spans_due[$];
   pulley_pair_type on_wire;
   int           errors = 0;
   int           n_sent = 0;
   int           cycles = 0;
   int           send_gap = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   bit           hold_done = 0;

   belt_tangent_points u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_first_diameter(req_first_diameter), .req_first_reverse(req_first_reverse),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .req_second_diameter(req_second_diameter),
      .req_second_reverse(req_second_reverse),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_start_x(rsp_start_x), .rsp_start_y(rsp_start_y),
      .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---- tangent point model ----
   function automatic logic [63:0] root_floor(input logic [127:0] v);
      logic [63:0]  r;
      logic [127:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = {64'b0, r | (64'd1 << b)};
         if (c * c <= v) r = c[63:0];
      end
      return r;
   endfunction

   function automatic longint scaled_offset(input logic [DIA_W-1:0] dia,
                                            input logic signed [191:0] num,
                                            input logic [127:0] s);
      logic [255:0] mag, q, den, half;
      mag  = '0;
      den  = {128'b0, s} << (QF_BITS + 1);
      half = {128'b0, s} << QF_BITS;
      if (num < 0) mag = -num;
      else mag = num;
      q = (mag * {225'b0, dia} + half) / den;
      if (q > (256'd1 << 62)) q = 256'd1 << 62;
      return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic logic signed [31:0] clamp_point(input longint centre,
                                                      input longint off);
      longint v;
      v = centre + off;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic span_type tangent_span(input pulley_pair_type p);
      span_type            t;
      longint              dx, dy;
      logic [63:0]         adx, ady, k, q;
      logic [127:0]        s, kk2;
      logic                kneg, eneg;
      logic signed [191:0] ks, ke, sdx, sdy, sq, nsx, nsy, nex, ney;
      t = '{default: '0, status: STATUS_OK};
      dx = 2 * (longint'(p.x2) - longint'(p.x1));
      dy = 2 * (longint'(p.y2) - longint'(p.y1));
      if ((dx == 0 && dy == 0) || p.d1 == 0 || p.d2 == 0) begin
         t.status = STATUS_DEGEN;
         return t;
      end
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (p.r1 != p.r2) begin
         k = p.d1 + p.d2;
         kneg = 1'b0;
         eneg = 1'b1;
      end else begin
         k = (p.d1 >= p.d2) ? p.d1 - p.d2 : p.d2 - p.d1;
         kneg = p.d1 < p.d2;
         eneg = 1'b0;
      end
      s   = {64'b0, adx} * {64'b0, adx} + {64'b0, ady} * {64'b0, ady};
      kk2 = {64'b0, k} * {64'b0, k};
      if (s < kk2) begin
         t.status = STATUS_NO_TAN;
         return t;
      end
      q   = root_floor((s - kk2) << (2 * QF_BITS));
      ks  = $signed({128'b0, k});
      if (kneg) ks = -ks;
      ke  = eneg ? -ks : ks;
      sdx = dx;
      sdy = dy;
      sq  = $signed({128'b0, q});
      nsx = ((ks * sdx) <<< QF_BITS) - (p.r1 ? -(sdy * sq) : sdy * sq);
      nsy = ((ks * sdy) <<< QF_BITS) + (p.r1 ? -(sdx * sq) : sdx * sq);
      nex = ((ke * sdx) <<< QF_BITS) - (p.r2 ? -(sdy * sq) : sdy * sq);
      ney = ((ke * sdy) <<< QF_BITS) + (p.r2 ? -(sdx * sq) : sdx * sq);
      t.sx = clamp_point(p.x1, scaled_offset(p.d1, nsx, s));
      t.sy = clamp_point(p.y1, scaled_offset(p.d1, nsy, s));
      t.ex = clamp_point(p.x2, scaled_offset(p.d2, nex, s));
      t.ey = clamp_point(p.y2, scaled_offset(p.d2, ney, s));
      return t;
   endfunction

   // ---- stimulus ----
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_pair(input int x1, y1, d1, r1, x2, y2, d2, r2,
                           input bit pause = 0);
      pulley_pair_type p;
      p.x1 = x1; p.y1 = y1; p.d1 = d1[DIA_W-1:0]; p.r1 = r1[0];
      p.x2 = x2; p.y2 = y2; p.d2 = d2[DIA_W-1:0]; p.r2 = r2[0];
      p.pause = pause;
      pending.push_back(p);
   endtask

   task automatic add_random_pair(input bit pause);
      int kind, bx, by, sep;
      kind = $urandom_range(0, 99);
      bx = $signed($urandom()) >>> $urandom_range(4, 8);
      by = $signed($urandom()) >>> $urandom_range(4, 8);
      if (kind < 60) begin
         sep = $urandom_range(1, 24);
         add_pair(bx, by, $urandom() >> (31 - $urandom_range(4, 24)), $urandom_range(0, 1),
                  bx + ($signed($urandom()) >>> (32 - sep)),
                  by + ($signed($urandom()) >>> (32 - sep)),
                  $urandom() >> (31 - $urandom_range(4, 24)), $urandom_range(0, 1), pause);
      end else if (kind < 75) begin
         add_pair($urandom(), $urandom(), $urandom(), $urandom_range(0, 1),
                  $urandom(), $urandom(), $urandom(), $urandom_range(0, 1), pause);
      end else if (kind < 85) begin
         // overlapping or nested circles
         add_pair(bx, by, $urandom_range(1 << 20, 1 << 22), $urandom_range(0, 1),
                  bx + $urandom_range(0, 1 << 19), by - $urandom_range(0, 1 << 19),
                  $urandom_range(1, 1 << 22), $urandom_range(0, 1), pause);
      end else if (kind < 92) begin
         sep = $urandom_range(1, 1 << 20);
         add_pair(bx, by, sep, $urandom_range(0, 1), bx + $urandom_range(0, 1 << 22),
                  by + $urandom_range(0, 1 << 22), sep, kind & 1, pause);
      end else begin
         add_pair(bx, by, $urandom_range(0, 3) == 0 ? 0 : $urandom(), $urandom_range(0, 1),
                  $urandom_range(0, 1) ? bx : $urandom(), by,
                  $urandom_range(0, 2) == 0 ? 0 : $urandom(), $urandom_range(0, 1), pause);
      end
   endtask

   initial begin
      // extremes of every field
      add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
               32'h80000000, 32'h80000000, 32'h7fffffff, 0);
      add_pair(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1,
               32'h7fffffff, 32'h80000000, 1, 0);
      add_pair(32'h80000000, 0, 1, 0, 32'h7fffffff, 0, 1, 1);
      add_pair(0, 0, 65536, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
      // degenerate: coincident centres, zero diameters
      add_pair(100, -200, 65536, 0, 100, -200, 65536, 0);
      add_pair(0, 0, 0, 0, 655360, 0, 65536, 0);
      add_pair(0, 0, 65536, 1, 655360, 0, 0, 1);
      add_pair(5, 5, 0, 0, 5, 5, 0, 1);
      // no tangent: overlapping crossed, nested open
      add_pair(0, 0, 131072, 0, 65536, 0, 131072, 1);
      add_pair(0, 0, 655360, 1, 65536, 0, 65536, 1);
      // equal radii, open belt, both senses
      add_pair(0, 0, 131072, 0, 655360, 0, 131072, 0);
      add_pair(0, 0, 131072, 1, 0, 655360, 131072, 1);
      add_pair(-655360, 327680, 65536, 0, 655360, -327680, 65536, 0);
      // touching circles, crossed and open
      add_pair(0, 0, 65536, 0, 65536, 0, 65536, 1);
      add_pair(0, 0, 196608, 1, 65536, 0, 65536, 1);
      // ordinary spans, all sign combinations
      add_pair(65536, 65536, 131072, 0, 1310720, 655360, 262144, 1);
      add_pair(65536, 65536, 131072, 1, 1310720, 655360, 262144, 0);
      add_pair(-65536, 65536, 262144, 0, -1310720, -655360, 131072, 0);
      add_pair(-65536, 65536, 262144, 1, -1310720, -655360, 131072, 1);
      add_pair(0, 0, 1, 0, 1, 1, 1, 1, 1);
      for (int i = 0; i < N_RANDOM; i++) add_random_pair(i == 1200);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending.size() == 0 && !req_valid);
      wait (spans_due.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---- driver ----
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            spans_due.push_back(tangent_span(on_wire));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0 &&
                         !(pending[0].pause && (req_valid || spans_due.size() > 0))) begin
               on_wire = pending.pop_front();
               req_first_x         <= on_wire.x1;
               req_first_y         <= on_wire.y1;
               req_first_diameter  <= on_wire.d1;
               req_first_reverse   <= on_wire.r1;
               req_second_x        <= on_wire.x2;
               req_second_y        <= on_wire.y2;
               req_second_diameter <= on_wire.d2;
               req_second_reverse  <= on_wire.r2;
               req_valid           <= 1'b1;
               // burst stretches with no gaps at all
               send_gap = ((n_sent % 400) < 120) ? 0 : gap_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---- monitor ----
   always @(posedge clock) begin
      span_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (spans_due.size() == 0) begin
            $display("%0t: response word with none expected", $realtime);
            errors++;
         end else begin
            e = spans_due.pop_front();
            if (rsp_start_x !== e.sx || rsp_start_y !== e.sy || rsp_end_x !== e.ex ||
                rsp_end_y !== e.ey || rsp_status !== e.status) begin
               $display("%0t: mismatch exp start (%0d,%0d) end (%0d,%0d) st %0d",
                        $realtime, e.sx, e.sy, e.ex, e.ey, e.status);
               $display("%0t:          got start (%0d,%0d) end (%0d,%0d) st %0d",
                        $realtime, rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y,
                        rsp_status);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && n_sent >= HOLD_AT) begin
         // long hold-off so the pipe fills and backs up the request side
         hold_done = 1;
         hold_left = HOLD_LEN;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = ((n_sent % 400) >= 200 && (n_sent % 400) < 320) ? 0 : gap_length();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule
